>>> sv/agc_pkg.sv
// Shared constants, types and controller/datapath interface for the gain control block.
`default_nettype none

package agc_pkg;

   // Sizing
   localparam int MAX_BLOCK = 128;
   localparam int SAMPLE_W  = 16;
   localparam int POS_W     = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W     = SAMPLE_W + $clog2(MAX_BLOCK);
   localparam int GAIN_W    = 32;
   localparam int STEP_W    = 40;
   localparam int RAMP_W    = 34 + $clog2(MAX_BLOCK);
   localparam int CFG_W     = 16;
   localparam int LEN_CFG_W = 8;
   localparam int MGAIN_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_W     = 48;
   localparam int DIVISOR_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_WEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAIN       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSMIT_SCALE = 2'd3;

   // Register reset values
   localparam logic [LEN_CFG_W-1:0] BLOCK_LENGTH_RST   = 8'd128;
   localparam logic [CFG_W-1:0]     AVG_WEIGHT_RST     = 16'd32768;
   localparam logic [CFG_W-1:0]     MAX_GAIN_RST       = 16'd1280;
   localparam logic [CFG_W-1:0]     TRANSMIT_SCALE_RST = 16'd256;

   // 32767 in Q16.16 shifted up by 16 more bits: numerator of the gain ratio
   localparam logic [DIV_W-1:0]     RATIO_NUM = 48'h7FFF_0000_0000;
   // 1.0 in Q16.16: floor of the weighted level
   localparam logic [GAIN_W-1:0]    GAIN_ONE  = 32'h0001_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPLY,
      S_AVG_GO,
      S_AVG_WAIT,
      S_WEIGHT,
      S_RATIO_GO,
      S_RATIO_WAIT,
      S_SCALE_CUR,
      S_SCALE_NEXT,
      S_STEP_GO,
      S_STEP_WAIT,
      S_FINISH
   } agc_state_type;

   typedef enum logic [1:0] {
      DIV_AVG,
      DIV_RATIO,
      DIV_STEP
   } div_op_type;

   typedef struct packed {
      logic       load_in;
      logic       apply;
      logic       div_start;
      div_op_type div_sel;
      logic       cap_avg;
      logic       cap_weight;
      logic       cap_ratio;
      logic       scale_cur;
      logic       scale_next;
      logic       finish;
   } agc_cmd_type;

   typedef struct packed {
      logic closed;
      logic div_done;
   } agc_stat_type;

endpackage

`default_nettype wire

>>> sv/agc_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module agc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [agc_pkg::DIV_W-1:0]     dividend,
   input  wire logic [agc_pkg::DIVISOR_W-1:0] divisor,
   output logic                               done,
   output logic [agc_pkg::DIV_W-1:0]          quotient
);
   import agc_pkg::*;

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      count_in   = count_ff;
      done_in    = done_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         count_in   = DIV_CNT_W'(DIV_W);
         done_in    = 1'b0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
         rem_in   = fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/agc_dp.sv
// Datapath: config registers, gain ramp, block statistics, gain update arithmetic.
`default_nettype none

module agc_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire agc_pkg::agc_cmd_type                 cmd,
   output agc_pkg::agc_stat_type                     stat,
   input  wire logic signed [agc_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic                                 req_frame_end,
   input  wire logic                                 csr_write,
   input  wire logic [agc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [agc_pkg::CFG_W-1:0]            csr_data,
   output logic signed [agc_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   output logic                                      rsp_block_closed
);
   import agc_pkg::*;

   localparam logic signed [RAMP_W-1:0] GAIN_LIM = {{(RAMP_W-32){1'b0}}, 32'h8000_0000};

   // Configuration
   logic [LEN_CFG_W-1:0] block_length_ff, block_length_in;
   logic [CFG_W-1:0]     avg_weight_ff, avg_weight_in;
   logic [CFG_W-1:0]     max_gain_ff, max_gain_in;
   logic [CFG_W-1:0]     transmit_scale_ff, transmit_scale_in;

   // Request holding
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       frame_end_ff, frame_end_in;

   // Gain and block state
   logic [GAIN_W-1:0]        current_gain_ff, current_gain_in;
   logic [GAIN_W-1:0]        next_gain_ff, next_gain_in;
   logic signed [STEP_W-1:0] gain_step_ff, gain_step_in;
   logic signed [RAMP_W-1:0] ramp_ff, ramp_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [SAMPLE_W-1:0]      peak_ff, peak_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;

   // Block close intermediates
   logic [SAMPLE_W-1:0]      avg_ff, avg_in;
   logic [GAIN_W-1:0]        weighted_ff, weighted_in;
   logic [MGAIN_W-1:0]       m_ff, m_in;

   // Response register
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_closed_ff, rsp_closed_in;

   // Combinational helpers
   logic [POS_W-1:0]         eff_len;
   logic [POS_W-1:0]         pos_plus;
   logic                     closed;
   logic signed [32:0]       gain_clamp;
   logic signed [48:0]       prod;
   logic signed [48:0]       prod_adj;
   logic signed [48:0]       prod_q;
   logic signed [SAMPLE_W-1:0] sat_out;
   logic [SAMPLE_W-1:0]      mag;
   logic [SAMPLE_W-1:0]      spread;
   logic [GAIN_W-1:0]        wprod;
   logic [GAIN_W-1:0]        weighted_raw;
   logic [MGAIN_W-1:0]       max_lim;
   logic [GAIN_W-1:0]        mul_a;
   logic [47:0]              mul_p;
   logic [39:0]              scaled;
   logic signed [GAIN_W:0]   gain_diff;
   logic [GAIN_W-1:0]        diff_mag;
   logic signed [STEP_W-1:0] step_q;
   logic [DIV_W-1:0]         div_dividend;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_done;
   logic [DIV_W-1:0]         div_quo;

   agc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Block length in force, clamped to 1..MAX_BLOCK
   always_comb begin
      if (block_length_ff == '0) begin
         eff_len = POS_W'(1);
      end else if (32'(block_length_ff) > 32'(MAX_BLOCK)) begin
         eff_len = POS_W'(MAX_BLOCK);
      end else begin
         eff_len = POS_W'(block_length_ff);
      end
      pos_plus = pos_ff + 1'b1;
      closed   = frame_end_ff || (pos_plus >= eff_len);
   end

   // Ramp gain clamp, multiply, truncate toward zero, saturate
   always_comb begin
      if (ramp_ff > GAIN_LIM) begin
         gain_clamp = 33'(GAIN_LIM);
      end else if (ramp_ff < -GAIN_LIM) begin
         gain_clamp = 33'(-GAIN_LIM);
      end else begin
         gain_clamp = 33'(ramp_ff);
      end
      prod     = sample_ff * gain_clamp;
      prod_adj = prod + (prod[48] ? 49'sd65535 : 49'sd0);
      prod_q   = prod_adj >>> 16;
      if (prod_q > 49'sd32767) begin
         sat_out = 16'sh7FFF;
      end else if (prod_q < -49'sd32768) begin
         sat_out = -16'sh8000;
      end else begin
         sat_out = prod_q[SAMPLE_W-1:0];
      end
      mag = sample_ff[SAMPLE_W-1] ? (~$unsigned(sample_ff) + 1'b1) : $unsigned(sample_ff);
   end

   // Weighted level: average pulled toward peak
   always_comb begin
      spread       = peak_ff - avg_ff;
      wprod        = 32'(spread) * 32'(avg_weight_ff);
      weighted_raw = {avg_ff, 16'h0000} + wprod;
   end

   // Gain limit and shared scale multiplier
   always_comb begin
      max_lim = {max_gain_ff, 8'h00};
      mul_a   = cmd.scale_cur ? next_gain_ff : {8'h00, m_ff};
      mul_p   = 48'(mul_a) * 48'(transmit_scale_ff);
      scaled  = mul_p[47:8];
   end

   // Step numerator and signed quotient
   always_comb begin
      gain_diff = $signed({1'b0, next_gain_ff}) - $signed({1'b0, current_gain_ff});
      diff_mag  = gain_diff[GAIN_W] ? GAIN_W'(-gain_diff) : gain_diff[GAIN_W-1:0];
      step_q    = $signed({{(STEP_W-GAIN_W){1'b0}}, div_quo[GAIN_W-1:0]});
   end

   // Divider operand select
   always_comb begin
      case (cmd.div_sel)
         DIV_RATIO: begin
            div_dividend = RATIO_NUM;
            div_divisor  = weighted_ff;
         end
         DIV_STEP: begin
            div_dividend = DIV_W'(diff_mag);
            div_divisor  = DIVISOR_W'(pos_ff - 1'b1);
         end
         default: begin
            div_dividend = DIV_W'(sum_ff);
            div_divisor  = DIVISOR_W'(pos_ff);
         end
      endcase
   end

   // Config writes
   always_comb begin
      block_length_in   = block_length_ff;
      avg_weight_in     = avg_weight_ff;
      max_gain_in       = max_gain_ff;
      transmit_scale_in = transmit_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLOCK_LENGTH:   block_length_in   = csr_data[LEN_CFG_W-1:0];
            CSR_AVG_WEIGHT:     avg_weight_in     = csr_data;
            CSR_MAX_GAIN:       max_gain_in       = csr_data;
            CSR_TRANSMIT_SCALE: transmit_scale_in = csr_data;
            default: ;
         endcase
      end
   end

   // Next state of the datapath
   always_comb begin
      sample_in       = sample_ff;
      frame_end_in    = frame_end_ff;
      current_gain_in = current_gain_ff;
      next_gain_in    = next_gain_ff;
      gain_step_in    = gain_step_ff;
      ramp_in         = ramp_ff;
      pos_in          = pos_ff;
      peak_in         = peak_ff;
      sum_in          = sum_ff;
      avg_in          = avg_ff;
      weighted_in     = weighted_ff;
      m_in            = m_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_closed_in   = rsp_closed_ff;

      if (cmd.load_in) begin
         sample_in    = req_sample_in;
         frame_end_in = req_frame_end;
      end

      // per-sample work: output, ramp advance, statistics
      if (cmd.apply) begin
         rsp_sample_in = sat_out;
         rsp_closed_in = closed;
         ramp_in       = ramp_ff + RAMP_W'(gain_step_ff);
         pos_in        = pos_plus;
         peak_in       = (mag > peak_ff) ? mag : peak_ff;
         sum_in        = sum_ff + SUM_W'(mag);
      end

      if (cmd.cap_avg) begin
         avg_in = div_quo[SAMPLE_W-1:0];
      end

      if (cmd.cap_weight) begin
         weighted_in = (weighted_raw < GAIN_ONE) ? GAIN_ONE : weighted_raw;
      end

      if (cmd.cap_ratio) begin
         if ((div_quo[DIV_W-1:MGAIN_W] != '0) || (div_quo[MGAIN_W-1:0] > max_lim)) begin
            m_in = max_lim;
         end else begin
            m_in = div_quo[MGAIN_W-1:0];
         end
      end

      if (cmd.scale_cur) begin
         current_gain_in = (scaled[39:GAIN_W] != '0) ? '1 : scaled[GAIN_W-1:0];
      end

      if (cmd.scale_next) begin
         next_gain_in = scaled[GAIN_W-1:0];
      end

      // new block starts from the fresh current gain
      if (cmd.finish) begin
         if (pos_ff == POS_W'(1)) begin
            gain_step_in = '0;
         end else if (gain_diff[GAIN_W]) begin
            gain_step_in = -step_q;
         end else begin
            gain_step_in = step_q;
         end
         ramp_in = $signed({{(RAMP_W-GAIN_W){1'b0}}, current_gain_ff});
         pos_in  = '0;
         peak_in = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff   <= BLOCK_LENGTH_RST;
         avg_weight_ff     <= AVG_WEIGHT_RST;
         max_gain_ff       <= MAX_GAIN_RST;
         transmit_scale_ff <= TRANSMIT_SCALE_RST;
         current_gain_ff   <= '0;
         next_gain_ff      <= '0;
         gain_step_ff      <= '0;
         ramp_ff           <= '0;
         pos_ff            <= '0;
         peak_ff           <= '0;
         sum_ff            <= '0;
      end else begin
         block_length_ff   <= block_length_in;
         avg_weight_ff     <= avg_weight_in;
         max_gain_ff       <= max_gain_in;
         transmit_scale_ff <= transmit_scale_in;
         current_gain_ff   <= current_gain_in;
         next_gain_ff      <= next_gain_in;
         gain_step_ff      <= gain_step_in;
         ramp_ff           <= ramp_in;
         pos_ff            <= pos_in;
         peak_ff           <= peak_in;
         sum_ff            <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      frame_end_ff  <= frame_end_in;
      avg_ff        <= avg_in;
      weighted_ff   <= weighted_in;
      m_ff          <= m_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_closed_ff <= rsp_closed_in;
   end

   assign stat.closed   = closed;
   assign stat.div_done = div_done;

   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_block_closed = rsp_closed_ff;

endmodule

`default_nettype wire

>>> sv/agc_ctrl.sv
// Controller: sequences each request and the gain update at block close.
`default_nettype none

module agc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire agc_pkg::agc_stat_type  stat,
   output agc_pkg::agc_cmd_type        cmd
);
   import agc_pkg::*;

   agc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_valid && !csr_valid) state_in = S_APPLY;
         S_APPLY: begin
            if (out_free) begin
               state_in = stat.closed ? S_AVG_GO : S_IDLE;
            end
         end
         S_AVG_GO:     state_in = S_AVG_WAIT;
         S_AVG_WAIT:   if (stat.div_done) state_in = S_WEIGHT;
         S_WEIGHT:     state_in = S_RATIO_GO;
         S_RATIO_GO:   state_in = S_RATIO_WAIT;
         S_RATIO_WAIT: if (stat.div_done) state_in = S_SCALE_CUR;
         S_SCALE_CUR:  state_in = S_SCALE_NEXT;
         S_SCALE_NEXT: state_in = S_STEP_GO;
         S_STEP_GO:    state_in = S_STEP_WAIT;
         S_STEP_WAIT:  if (stat.div_done) state_in = S_FINISH;
         S_FINISH:     state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Commands; a config write in idle goes ahead of a request
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            csr_ready   = 1'b1;
            req_ready   = !csr_valid;
            cmd.load_in = req_valid && !csr_valid;
         end
         S_APPLY:      cmd.apply = out_free;
         S_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_AVG;
         end
         S_AVG_WAIT:   cmd.cap_avg = stat.div_done;
         S_WEIGHT:     cmd.cap_weight = 1'b1;
         S_RATIO_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RATIO;
         end
         S_RATIO_WAIT: cmd.cap_ratio = stat.div_done;
         S_SCALE_CUR:  cmd.scale_cur = 1'b1;
         S_SCALE_NEXT: cmd.scale_next = 1'b1;
         S_STEP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_STEP;
         end
         S_STEP_WAIT:  ;
         S_FINISH:     cmd.finish = 1'b1;
         default:      ;
      endcase
   end

   // Response valid: set when a result loads, cleared when taken
   always_comb begin
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/block_automatic_gain_control.sv
// Top level of the automatic gain control block.
//
//   channel   prefix  direction  handshake        payload
//   request   req_    in         valid / ready    sample_in, frame_end
//   response  rsp_    out        valid / ready    sample_out, block_closed
//   config    csr_    in         valid / ready    index, data
//
// A request is accepted in idle, then the apply step does the ramp gain multiply
// and the statistics update, which loads the response register.
// A request that closes a block runs the gain update: average divide, weight,
// ratio divide, scale current, scale next, step divide, finish; each divide is a
// start, 48 shift steps and done. Apply stalls while a result waits untaken.
// Config writes are taken only while idle, ahead of a waiting request.
// Synchronous active-high reset; gains start at zero, so the first block is muted.
`default_nettype none

module block_automatic_gain_control (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [agc_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic                                 req_frame_end,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [agc_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   output logic                                      rsp_block_closed,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [agc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [agc_pkg::CFG_W-1:0]            csr_data
);
   import agc_pkg::*;

   agc_cmd_type  cmd;
   agc_stat_type stat;
   logic         csr_write;

   // Config writes land only between requests, never during a gain update
   assign csr_write = csr_valid && csr_ready;

   agc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   agc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_sample_in    (req_sample_in),
      .req_frame_end    (req_frame_end),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_block_closed (rsp_block_closed)
   );

endmodule

`default_nettype wire
